### rtl/gba_pkg.sv
package gba_pkg;

  localparam int MaxGroups     = 16;
  localparam int WordBits      = 64;
  localparam int MaxEpg        = 2048;
  localparam int WordsPerGroup = MaxEpg / WordBits;
  localparam int MemDepth      = MaxGroups * WordsPerGroup;
  localparam int GroupW        = $clog2(MaxGroups);
  localparam int WordIdxW      = $clog2(WordsPerGroup);
  localparam int BitIdxW       = $clog2(WordBits);
  localparam int AddrW         = GroupW + WordIdxW;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoSpace = 2'd1;
  localparam logic [1:0] StatusInvalid = 2'd2;

  localparam logic RegGroupCount = 1'b0;
  localparam logic RegEpg        = 1'b1;

  localparam logic ModeAlloc = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PICK,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_FREAD,
    ST_FCHECK,
    ST_SUM,
    ST_DONE
  } state_t;

  function automatic logic [11:0] group_free(input logic [11:0] used, input logic [11:0] epg);
    group_free = (used >= epg) ? 12'd0 : epg - used;
  endfunction

endpackage

### rtl/grouped_bitmap_id_allocator.sv
// Channel  Direction  tdata / tuser contents (low bits first)
// s_*      in         tdata: group_hint[4:0], entry_number[20:5]; tuser: mode
// m_*      out        tdata: status[1:0], allocated_number[17:2], was_in_use[18],
//                            total_free[34:19]
// cfg_*    in         cfg_index selects group_count (0) or entries_per_group (1)
//
// One word at a time. An allocate reads and checks bitmap words in turn (up to 32
// words), after a group choice pass when the hint asks for one; a free divides the
// entry number by the group size, then reads and writes the bitmap word. Every word
// ends with a pass summing free counts. After reset a clearing pass writes
// all 512 bitmap words, one per cycle, before the first word is taken. A finished
// result waits in the output register; the next word is accepted meanwhile.
module grouped_bitmap_id_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // group_hint, entry_number
  input  logic        s_tuser,  // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // status, allocated_number, was_in_use, total_free
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);
  import gba_pkg::*;

  logic [WordBits-1:0] mem [MemDepth];
  logic [WordBits-1:0] rdata;
  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr, mem_raddr;
  logic [WordBits-1:0] mem_wdata;

  state_t state, state_next;

  logic [4:0]  group_count;
  logic [11:0] entries_per_group;
  logic [11:0] used [MaxGroups];

  logic [AddrW:0]       clr_cnt;
  logic [GroupW-1:0]    grp, idx;
  logic [4:0]           div_g;
  logic [15:0]          rem;
  logic [11:0]          best;
  logic [WordIdxW-1:0]  widx;
  logic [15:0]          acc;
  logic [1:0]           status;
  logic [15:0]          number;
  logic                 was;

  logic [4:0]  ng;
  logic [11:0] epg;
  logic [5:0]  nw;
  logic [11:0] f_idx;
  logic        last_idx;
  logic [BitIdxW-1:0] zpos;
  logic        word_full;
  logic [BitIdxW-1:0] fbit;

  always_comb begin
    ng = group_count;
    if (ng == 5'd0) ng = 5'd1;
    if (ng > 5'(MaxGroups)) ng = 5'(MaxGroups);
    epg = (entries_per_group > 12'(MaxEpg)) ? 12'(MaxEpg) : entries_per_group;
    epg = {epg[11:6], 6'd0};
    if (epg == 12'd0) epg = 12'(WordBits);
    nw = epg[11:6];
  end

  assign f_idx    = group_free(used[idx], epg);
  assign last_idx = ({1'b0, idx} == ng - 5'd1);
  assign word_full = &rdata;
  assign fbit     = rem[BitIdxW-1:0];

  always_comb begin
    zpos = '0;
    for (int k = WordBits - 1; k >= 0; k--) begin
      if (!rdata[k]) zpos = BitIdxW'(k);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == (AddrW+1)'(MemDepth - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser != ModeAlloc) begin
            state_next = (s_tdata[20:5] == 16'd0) ? ST_SUM : ST_DIV;
          end else if (s_tdata[4]) begin
            state_next = ST_PICK;
          end else if (s_tdata[4:0] >= ng) begin
            state_next = ST_SUM;
          end else if (group_free(used[s_tdata[GroupW-1:0]], epg) == 12'd0) begin
            state_next = ST_SUM;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_PICK: begin
        if (last_idx) state_next = (best == 12'd0 && f_idx == 12'd0) ? ST_SUM : ST_READ;
      end
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (!word_full || {1'b0, widx} == nw - 6'd1) state_next = ST_SUM;
        else state_next = ST_READ;
      end
      ST_DIV: begin
        if (div_g >= ng) state_next = ST_SUM;
        else if (rem < {4'd0, epg}) state_next = ST_FREAD;
      end
      ST_FREAD:  state_next = ST_FCHECK;
      ST_FCHECK: state_next = ST_SUM;
      ST_SUM: begin
        if (last_idx) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {grp, widx};
    mem_wdata = rdata | (WordBits'(1) << zpos);
    mem_raddr = {grp, widx};
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt[AddrW-1:0];
        mem_wdata = '0;
      end
      ST_CHECK: mem_we = !word_full;
      ST_FREAD: mem_raddr = {grp, rem[10:6]};
      ST_FCHECK: begin
        mem_we    = rdata[fbit];
        mem_waddr = {grp, rem[10:6]};
        mem_wdata = rdata & ~(WordBits'(1) << fbit);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_CLEAR;
      clr_cnt           <= '0;
      group_count       <= 5'd16;
      entries_per_group <= 12'd2048;
      m_tvalid          <= 1'b0;
      for (int k = 0; k < MaxGroups; k++) used[k] <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == RegGroupCount) group_count <= cfg_data[4:0];
        else entries_per_group <= cfg_data;
      end
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        ST_IDLE: begin
          rem    <= s_tdata[20:5] - 16'd1;
          div_g  <= '0;
          grp    <= s_tdata[GroupW-1:0];
          idx    <= '0;
          best   <= '0;
          widx   <= '0;
          acc    <= '0;
          number <= '0;
          was    <= 1'b0;
          status <= StatusOk;
          if (s_tvalid) begin
            if (s_tuser != ModeAlloc) begin
              if (s_tdata[20:5] == 16'd0) status <= StatusInvalid;
            end else if (!s_tdata[4]) begin
              if (s_tdata[4:0] >= ng) status <= StatusInvalid;
              else if (group_free(used[s_tdata[GroupW-1:0]], epg) == 12'd0)
                status <= StatusNoSpace;
            end
          end
        end
        ST_PICK: begin
          if (f_idx > best) begin
            best <= f_idx;
            grp  <= idx;
          end
          idx <= last_idx ? '0 : idx + 1'b1;
          if (last_idx && best == 12'd0 && f_idx == 12'd0) status <= StatusNoSpace;
        end
        ST_CHECK: begin
          if (!word_full) begin
            used[grp] <= used[grp] + 12'd1;
            number <= 16'(grp) * 16'(epg) + {5'd0, widx, 6'd0} + 16'(zpos) + 16'd1;
          end else if ({1'b0, widx} == nw - 6'd1) begin
            status <= StatusNoSpace;
          end else begin
            widx <= widx + 1'b1;
          end
        end
        ST_DIV: begin
          if (div_g >= ng) begin
            status <= StatusInvalid;
          end else if (rem < {4'd0, epg}) begin
            grp <= div_g[GroupW-1:0];
          end else begin
            rem   <= rem - {4'd0, epg};
            div_g <= div_g + 5'd1;
          end
        end
        ST_FCHECK: begin
          if (rdata[fbit]) begin
            was <= 1'b1;
            if (used[grp] != 12'd0) used[grp] <= used[grp] - 12'd1;
          end
        end
        ST_SUM: begin
          acc <= acc + {4'd0, f_idx};
          idx <= last_idx ? '0 : idx + 1'b1;
        end
        ST_DONE: begin
          // A result still waiting stays valid until taken.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, acc, was, number, status};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### test/grouped_bitmap_id_allocator_tb.sv
`timescale 1ns / 1ps

module grouped_bitmap_id_allocator_tb;
  import gba_pkg::*;

  typedef struct packed {
    logic        mode;
    logic [4:0]  hint;
    logic [15:0] number;
  } request_t;

  // Packed from the top bit down, so status lands in the lowest bits.
  typedef struct packed {
    logic [15:0] free_total;
    logic        was_set;
    logic [15:0] granted;
    logic [1:0]  status;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [11:0] cfg_data = '0;

  grouped_bitmap_id_allocator u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the allocator state.
  logic [WordBits-1:0] occ_map [MemDepth];
  logic [11:0] used_in_group [MaxGroups];
  logic [4:0]  groups_reg;
  logic [11:0] epg_reg;

  request_t pending_words[$];
  reply_t   expected_replies[$];
  int       mismatch_count = 0;
  bit       hold_sender = 1'b0;
  int       send_gap = 0;
  int       recv_gap = 0;

  function automatic int live_groups();
    int g;
    g = groups_reg;
    if (g == 0) g = 1;
    if (g > MaxGroups) g = MaxGroups;
    return g;
  endfunction

  function automatic int live_epg();
    int e;
    e = epg_reg;
    if (e > MaxEpg) e = MaxEpg;
    e = (e / WordBits) * WordBits;
    if (e == 0) e = WordBits;
    return e;
  endfunction

  function automatic int free_in(int g, int e);
    return (used_in_group[g] >= e) ? 0 : e - used_in_group[g];
  endfunction

  function automatic reply_t allocate_or_release(request_t rq);
    reply_t r;
    int ng, e, g, best, w, b, idx, bit_pos;
    bit ok, found;
    ng = live_groups();
    e = live_epg();
    r = '0;
    if (rq.mode == ModeAlloc) begin
      g = 0;
      ok = 1'b1;
      if (rq.hint[4]) begin
        best = 0;
        for (int i = 0; i < ng; i++) begin
          if (free_in(i, e) > best) begin
            best = free_in(i, e);
            g = i;
          end
        end
        if (best == 0) begin
          r.status = StatusNoSpace;
          ok = 1'b0;
        end
      end else if (rq.hint >= ng) begin
        r.status = StatusInvalid;
        ok = 1'b0;
      end else begin
        g = rq.hint;
        if (free_in(g, e) == 0) begin
          r.status = StatusNoSpace;
          ok = 1'b0;
        end
      end
      if (ok) begin
        found = 1'b0;
        for (w = 0; w < e / WordBits && !found; w++) begin
          if (occ_map[g * WordsPerGroup + w] != '1) begin
            b = 0;
            while (occ_map[g * WordsPerGroup + w][b]) b++;
            occ_map[g * WordsPerGroup + w][b] = 1'b1;
            used_in_group[g]++;
            r.granted = 16'(g * e + w * WordBits + b + 1);
            found = 1'b1;
          end
        end
        if (!found) r.status = StatusNoSpace;
      end
    end else if (rq.number == 0) begin
      r.status = StatusInvalid;
    end else begin
      idx = rq.number - 1;
      g = idx / e;
      if (g >= ng) begin
        r.status = StatusInvalid;
      end else begin
        bit_pos = idx % e;
        w = g * WordsPerGroup + bit_pos / WordBits;
        b = bit_pos % WordBits;
        if (occ_map[w][b]) begin
          occ_map[w][b] = 1'b0;
          if (used_in_group[g] > 0) used_in_group[g]--;
          r.was_set = 1'b1;
        end
      end
    end
    best = 0;
    for (int i = 0; i < ng; i++) best += free_in(i, e);
    r.free_total = 16'(best);
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 120);
    return $urandom_range(1, 4);
  endfunction

  // Sender: a word moves when s_tvalid and s_tready are both high.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_replies.push_back(allocate_or_release(pending_words.pop_front()));
        send_gap = pick_gap();
      end
      if ((!s_tvalid || s_tready) && send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if ((!s_tvalid || s_tready) && !hold_sender) begin
        if (pending_words.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= {3'd0, pending_words[0].number, pending_words[0].hint};
          s_tuser <= pending_words[0].mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end else if (!s_tvalid || s_tready) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    reply_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[34:0];
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected word %h", got);
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status || got.granted !== want.granted ||
              got.was_set !== want.was_set || got.free_total !== want.free_total) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display(
                "mismatch exp st=%0d num=%0d was=%0b free=%0d got st=%0d num=%0d was=%0b free=%0d",
                want.status, want.granted, want.was_set, want.free_total,
                got.status, got.granted, got.was_set, got.free_total);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (m_tvalid && m_tready) recv_gap = pick_gap();
      end
    end
  end

  task automatic add_word(logic mode, logic [4:0] hint, logic [15:0] number);
    request_t rq;
    rq.mode = mode;
    rq.hint = hint;
    rq.number = number;
    pending_words.push_back(rq);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || s_tvalid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic index, logic [11:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    if (index == RegGroupCount) groups_reg = value[4:0];
    else epg_reg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_word(ModeAlloc, 5'h1f, 16'($urandom));
        3, 4: add_word(ModeAlloc, 5'($urandom_range(0, 17)), 16'($urandom));
        5: add_word(ModeAlloc, 5'($urandom), 16'($urandom));
        6, 7: add_word(1'b1, 5'($urandom), 16'($urandom_range(1, live_groups() * live_epg())));
        8: add_word(1'b1, 5'($urandom), 16'($urandom));
        default: add_word(1'b1, 5'($urandom), 16'($urandom_range(0, 3)));
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < MemDepth; i++) occ_map[i] = '0;
    for (int i = 0; i < MaxGroups; i++) used_in_group[i] = '0;
    groups_reg = 5'd16;
    epg_reg = 12'd2048;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: every mode, hint extremes, bad numbers, double free.
    add_word(ModeAlloc, 5'h1f, 16'hffff);
    add_word(ModeAlloc, 5'd0, 16'd0);
    add_word(ModeAlloc, 5'd15, 16'd0);
    add_word(ModeAlloc, 5'h10, 16'd0);
    add_word(ModeAlloc, 5'h0f, 16'd0);
    add_word(1'b1, 5'd0, 16'd0);
    add_word(1'b1, 5'h1f, 16'd1);
    add_word(1'b1, 5'd0, 16'd1);
    add_word(1'b1, 5'd0, 16'd32768);
    add_word(1'b1, 5'd0, 16'd32769);
    add_word(1'b1, 5'd0, 16'hffff);
    add_word(1'b1, 5'd0, 16'd2049);
    drain();

    // Small groups so they fill up: full named group and full store.
    write_reg(RegGroupCount, 12'd2);
    write_reg(RegEpg, 12'd64);
    for (int i = 0; i < 70; i++) add_word(ModeAlloc, 5'd1, 16'd0);
    for (int i = 0; i < 70; i++) add_word(ModeAlloc, 5'h1f, 16'd0);
    add_word(ModeAlloc, 5'd2, 16'd0);
    add_word(ModeAlloc, 5'd16, 16'd0);
    drain();
    hold_sender = 1'b1;
    random_phase(300);
    repeat (100) @(posedge clk);
    hold_sender = 1'b0;
    drain();

    // Out of range register values.
    write_reg(RegGroupCount, 12'd0);
    write_reg(RegEpg, 12'd0);
    random_phase(200);
    drain();
    write_reg(RegGroupCount, 12'd31);
    write_reg(RegEpg, 12'hfff);
    random_phase(300);
    drain();
    write_reg(RegGroupCount, 12'd5);
    write_reg(RegEpg, 12'd100);
    random_phase(250);
    drain();
    write_reg(RegGroupCount, 12'd16);
    write_reg(RegEpg, 12'd128);
    random_phase(250);
    drain();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
